[rtl/dwpw_pkg.sv]
// Package for the display window pixel writer.
// Holds the word types, register index codes and queue sizing.
// Every module in rtl/ imports it; it depends on nothing.
package dwpw_pkg;

    localparam int unsigned VALUE_W = 16;
    localparam int unsigned INDEX_W = 8;
    localparam int unsigned PITCH_W = 13;
    localparam int unsigned ADDR_W  = 29;

    localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(480);

    localparam logic OP_SELECT = 1'b0;
    localparam logic OP_DATA   = 1'b1;

    localparam logic [INDEX_W-1:0] IDX_LEFT   = 8'h01;
    localparam logic [INDEX_W-1:0] IDX_RIGHT  = 8'h02;
    localparam logic [INDEX_W-1:0] IDX_TOP    = 8'h03;
    localparam logic [INDEX_W-1:0] IDX_BOTTOM = 8'h04;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic               op;
        logic [VALUE_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic               write_valid;
        logic [ADDR_W-1:0]  pixel_address;
        logic [VALUE_W-1:0] pixel_color;
    } t_out_word;

    typedef struct packed {
        logic               write_valid;
        logic [VALUE_W-1:0] row;
        logic [VALUE_W-1:0] column;
        logic [VALUE_W-1:0] color;
    } t_cmd;

endpackage

[rtl/display_window_pixel_writer_unit.sv]
// Display window pixel writer: window-addressed pixel port over a linear frame buffer.
// Top level; instantiates dwpw_front, dwpw_queue and dwpw_back from dwpw_pkg.
//
// Input channel: i_in_valid / o_in_stall carry words {op, value}. op = 0 selects
// a register index, op = 1 writes data to it. Indices 1..4 set the window left,
// right, top and bottom edges (left and top also load the cursors); any other
// index writes a pixel and advances the cursor in raster order through the window.
// Output channel: o_out_valid / i_out_stall carry one word per input word:
// {write_valid, pixel_address, pixel_color}, all zero when no pixel is written.
// Configuration: i_cfg_we writes i_cfg_data into line_pitch, the row multiplier.
// Throughput: one word per cycle on both channels while i_out_stall is low. Each
// word passes the queue, the multiply stage, then the add into the output register.
// Reset (synchronous, active low) clears the window, cursors and index, loads
// line_pitch with 480 and empties the queue and pipeline.
// While the receiver stalls, the output word holds, the pipeline and two-entry
// queue fill, and o_in_stall rises once the queue is full.
module display_window_pixel_writer_unit import dwpw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [PITCH_W-1:0] i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_word           i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_word          o_out_word
);

    logic [PITCH_W-1:0] r_line_pitch;
    logic               q_push;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    t_cmd               push_cmd;
    t_cmd               pop_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_pitch <= PITCH_RESET;
        end else if (i_cfg_we) begin
            r_line_pitch <= i_cfg_data;
        end
    end

    dwpw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_cmd    (push_cmd)
    );

    dwpw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (pop_cmd)
    );

    dwpw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_line_pitch (r_line_pitch),
        .i_q_valid    (q_valid),
        .i_q_cmd      (pop_cmd),
        .o_q_pop      (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_word   (o_out_word)
    );

endmodule

[rtl/dwpw_front.sv]
// Front end: takes input words, keeps the register index, window and cursors.
// Issues one command per word into the queue. Depends on dwpw_pkg.
module dwpw_front import dwpw_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_word i_in_word,
    input  logic     i_q_full,
    output logic     o_q_push,
    output t_cmd     o_q_cmd
);

    logic [INDEX_W-1:0] r_sel, n_sel;
    logic [VALUE_W-1:0] r_left, n_left;
    logic [VALUE_W-1:0] r_right, n_right;
    logic [VALUE_W-1:0] r_top, n_top;
    logic [VALUE_W-1:0] r_bottom, n_bottom;
    logic [VALUE_W-1:0] r_col, n_col;
    logic [VALUE_W-1:0] r_row, n_row;
    logic [VALUE_W-1:0] col_inc;
    logic [VALUE_W-1:0] row_inc;
    logic               accept;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign o_q_push   = accept;
    assign col_inc    = r_col + VALUE_W'(1);
    assign row_inc    = r_row + VALUE_W'(1);

    always_comb begin
        n_sel    = r_sel;
        n_left   = r_left;
        n_right  = r_right;
        n_top    = r_top;
        n_bottom = r_bottom;
        n_col    = r_col;
        n_row    = r_row;
        o_q_cmd  = '0;
        if (accept) begin
            if (i_in_word.op == OP_SELECT) begin
                n_sel = i_in_word.value[INDEX_W-1:0];
            end else begin
                case (r_sel)
                    IDX_LEFT: begin
                        n_left = i_in_word.value;
                        n_col  = i_in_word.value;
                    end
                    IDX_RIGHT: begin
                        n_right = i_in_word.value;
                    end
                    IDX_TOP: begin
                        n_top = i_in_word.value;
                        n_row = i_in_word.value;
                    end
                    IDX_BOTTOM: begin
                        n_bottom = i_in_word.value;
                    end
                    default: begin
                        o_q_cmd.write_valid = 1'b1;
                        o_q_cmd.row         = r_row;
                        o_q_cmd.column      = r_col;
                        o_q_cmd.color       = i_in_word.value;
                        if (col_inc > r_right) begin
                            n_col = r_left;
                            n_row = (row_inc > r_bottom) ? r_top : row_inc;
                        end else begin
                            n_col = col_inc;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel    <= '0;
            r_left   <= '0;
            r_right  <= '0;
            r_top    <= '0;
            r_bottom <= '0;
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            r_sel    <= n_sel;
            r_left   <= n_left;
            r_right  <= n_right;
            r_top    <= n_top;
            r_bottom <= n_bottom;
            r_col    <= n_col;
            r_row    <= n_row;
        end
    end

endmodule

[rtl/dwpw_queue.sv]
// Short command queue between front and back ends.
// Depth set by QUEUE_DEPTH in dwpw_pkg.
module dwpw_queue import dwpw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              push;
    logic              pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (push && !pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[rtl/dwpw_back.sv]
// Back end: computes pitch * row + column and drives the output word.
// Multiply stage, then add into the output register. Depends on dwpw_pkg.
module dwpw_back import dwpw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [PITCH_W-1:0] i_line_pitch,
    input  logic               i_q_valid,
    input  t_cmd               i_q_cmd,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_word          o_out_word
);

    logic              r_s1_valid;
    t_cmd              r_s1_cmd;
    logic [ADDR_W-1:0] r_s1_prod;
    logic              r_out_valid;
    t_out_word         r_out_word;
    logic              out_free;
    logic              s1_move;
    logic              s1_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign s1_move     = r_s1_valid && out_free;
    assign s1_free     = !r_s1_valid || s1_move;
    assign o_q_pop     = i_q_valid && s1_free;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_cmd  <= i_q_cmd;
            r_s1_prod <= ADDR_W'(i_line_pitch) * ADDR_W'(i_q_cmd.row);
        end
        if (s1_move) begin
            r_out_word.write_valid   <= r_s1_cmd.write_valid;
            r_out_word.pixel_address <= r_s1_prod + ADDR_W'(r_s1_cmd.column);
            r_out_word.pixel_color   <= r_s1_cmd.color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_q_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

endmodule
